### design/rsu_pkg.sv
// rsu_pkg: types, codes and the digit decoder shared by the radix string
// to unsigned converter. No dependencies.
package rsu_pkg;

  localparam int VALUE_W     = 64;
  localparam int CHAR_W      = 8;
  localparam int RADIX_W     = 8;
  localparam int DIGIT_W     = 6;
  localparam int PROD_W      = VALUE_W + DIGIT_W;
  localparam int CFG_IDX_W   = 1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd10;
  localparam logic [RADIX_W-1:0] MAX_RADIX   = 8'd36;
  localparam logic [DIGIT_W-1:0] DIGIT_NONE  = 6'd63;

  localparam logic [CHAR_W-1:0] CHAR_0    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9    = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LA   = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LZ   = 8'h7a;
  localparam logic [CHAR_W-1:0] CHAR_UA   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UZ   = 8'h5a;
  localparam logic [CHAR_W-1:0] CHAR_APOS = 8'h27;
  localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX   = 1'b0,
    CFG_CEILING = 1'b1
  } cfg_idx_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_DIGIT     = 3'd0,
    ST_SEP       = 3'd1,
    ST_NOT_DIGIT = 3'd2,
    ST_BEYOND    = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_IGNORED   = 3'd5,
    ST_BAD_RADIX = 3'd6
  } status_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic               done_res;
  } out_item_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_EVAL
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic mul;
    logic eval;
    logic cfg_wr;
  } cmd_t;

  // digit value of a character byte, DIGIT_NONE if not a digit or letter
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = DIGIT_NONE;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      d = DIGIT_W'(c - CHAR_0);
    end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
      d = DIGIT_W'(c - CHAR_LA + LETTER_OFS);
    end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
      d = DIGIT_W'(c - CHAR_UA + LETTER_OFS);
    end
    return d;
  endfunction

endpackage

### design/rsu_ctrl.sv
// rsu_ctrl: sequencer of the converter: capture, multiply, evaluate,
// and the output beat flag. Depends on rsu_pkg.
module rsu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  output rsu_pkg::cmd_t cmd
);
  import rsu_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_full;
  logic   out_full_next;
  logic   eval_go;

  // evaluation writes the output register only when it is free or draining
  assign eval_go = (state == S_EVAL) && (!out_full || out_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (eval_go) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    in_ready    = (state == S_IDLE);
    cfg_ready   = 1'b1;
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.mul     = (state == S_MUL);
    cmd.eval    = eval_go;
    cmd.cfg_wr  = cfg_valid;
  end

  // output beat pending flag
  always_comb begin
    out_full_next = out_full;
    if (eval_go) out_full_next = 1'b1;
    else if (out_ready) out_full_next = 1'b0;
  end

  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

endmodule

### design/rsu_datapath.sv
// rsu_datapath: configuration registers, accumulator, multiply stage,
// overflow compare and output register. Depends on rsu_pkg.
module rsu_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  rsu_pkg::cmd_t                     cmd,
  input  rsu_pkg::in_item_t                 in_data,
  input  logic [rsu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsu_pkg::VALUE_W-1:0]       cfg_data,
  output rsu_pkg::out_item_t                out_data
);
  import rsu_pkg::*;

  logic [RADIX_W-1:0] radix;
  logic [VALUE_W-1:0] ceiling;
  logic [VALUE_W-1:0] accum;
  logic               stopped;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;
  logic [DIGIT_W-1:0] digit_q;
  logic [PROD_W-1:0]  prod_q;

  logic               bad_radix;
  logic [VALUE_W-1:0] ceil_eff;
  logic [PROD_W:0]    sum;
  logic               overflow;
  logic [VALUE_W-1:0] accum_next;
  logic               stopped_next;
  out_item_t          res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix   <= RADIX_RESET;
      ceiling <= '0;
    end else if (cmd.cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RADIX:   radix   <= cfg_data[RADIX_W-1:0];
        CFG_CEILING: ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  // input capture and multiply stage
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      char_q <= in_data.char_code;
      last_q <= in_data.last_char;
    end
    if (cmd.mul) begin
      digit_q <= digit_of(char_q);
      prod_q  <= PROD_W'(accum) * PROD_W'(radix[DIGIT_W-1:0]);
    end
  end

  // overflow test: accum * radix + digit must not pass the ceiling
  assign bad_radix = (radix == '0) || (radix > MAX_RADIX);
  assign ceil_eff  = (ceiling == '0) ? '1 : ceiling;
  assign sum       = {1'b0, prod_q} + (PROD_W + 1)'(digit_q);
  assign overflow  = sum > (PROD_W + 1)'(ceil_eff);

  // character evaluation
  always_comb begin
    accum_next   = accum;
    stopped_next = stopped;
    res.done_res = last_q;
    res.value    = accum;
    res.status   = ST_DIGIT;
    priority if (bad_radix) begin
      res.status = ST_BAD_RADIX;
      res.value  = '0;
    end else if (stopped) begin
      res.status = ST_IGNORED;
    end else if (char_q == CHAR_APOS) begin
      res.status = ST_SEP;
    end else if (digit_q == DIGIT_NONE) begin
      res.status   = ST_NOT_DIGIT;
      stopped_next = 1'b1;
    end else if (RADIX_W'(digit_q) >= radix) begin
      res.status   = ST_BEYOND;
      stopped_next = 1'b1;
    end else if (overflow) begin
      res.status   = ST_OVERFLOW;
      stopped_next = 1'b1;
    end else begin
      accum_next = sum[VALUE_W-1:0];
      res.value  = sum[VALUE_W-1:0];
      res.status = ST_DIGIT;
    end
    // end of string clears the state
    if (last_q) begin
      accum_next   = '0;
      stopped_next = 1'b0;
    end
  end

  // accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      accum   <= '0;
      stopped <= 1'b0;
    end else if (cmd.eval) begin
      accum   <= accum_next;
      stopped <= stopped_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.eval) out_data <= res;
  end

endmodule

### design/radix_string_to_unsigned.sv
// An accepted input beat is captured, passes the multiply stage and is
// evaluated into the output register; evaluation waits while a result is stalled.
// One character is in work at a time: the sequencer steps the multiply and
// the overflow compare of each character in turn before taking the next.
// Reset (rst, synchronous): radix 10, ceiling 0, accumulator cleared,
// accepting digits, no result pending.
module radix_string_to_unsigned (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rsu_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rsu_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rsu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsu_pkg::VALUE_W-1:0]   cfg_data
);
  import rsu_pkg::*;

  cmd_t cmd;

  // sequencer
  rsu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // arithmetic and state
  rsu_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

### design/rsu_checker.sv
// rsu_checker: port level assertions for radix_string_to_unsigned and the
// bind that attaches them. Depends on rsu_pkg.
module rsu_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input rsu_pkg::out_item_t            out_data
);
  import rsu_pkg::*;

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // one character at a time: no input beat right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous character in work");

  // a bad radix always reports zero
  a_bad_radix_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_BAD_RADIX) |-> (out_data.value == '0))
    else $error("bad radix result with nonzero value");

endmodule

bind radix_string_to_unsigned rsu_checker u_rsu_checker (.*);
